// ----- hw/rtl/fees_pkg.sv -----
// Package for the flash EEPROM record store: beat types, status codes, CRC helper.
// Used by fees_ctrl and the top level; depends on nothing.
package fees_pkg;

    localparam int PAGE_WORDS_DEF = 512;

    localparam logic [7:0] ID_BLANK  = 8'hFF;
    localparam logic [7:0] POLY_REFL = 8'hE0;
    localparam logic [7:0] CRC_INIT  = 8'hFF;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_CRC_BAD   = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic        func;
        logic [7:0]  identifier;
        logic [15:0] write_value;
    } req_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] read_value;
    } rsp_beat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WCRC1,
        S_WCRC2,
        S_SCAN,
        S_CHK1,
        S_CHK2,
        S_DECIDE,
        S_CLEAR,
        S_XFER,
        S_APPEND,
        S_DONE
    } state_t;

    // Reflected CRC-8 of one byte, register cleared
    function automatic logic [7:0] crc_byte(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/fees_flash_mem.sv -----
// Flash array of both pages: one write port, one registered read port.
// Depends on nothing.
module fees_flash_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/fees_ctrl.sv -----
// Sequencer of the record store: scan, CRC check, page transfer and append.
// Depends on fees_pkg; drives the flash array in fees_flash_mem.
module fees_ctrl #(
    parameter int PAGE_WORDS = fees_pkg::PAGE_WORDS_DEF,
    parameter int AW = $clog2(2 * PAGE_WORDS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fees_pkg::req_beat_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fees_pkg::rsp_beat_t rsp,
    output logic [AW-1:0]       mem_raddr,
    input  logic [31:0]         mem_rdata,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [31:0]         mem_wdata
);

    localparam int IW = $clog2(PAGE_WORDS);
    localparam int FW = $clog2(PAGE_WORDS + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(PAGE_WORDS);
    localparam logic [IW-1:0] TOP_IDX = IW'(PAGE_WORDS - 1);
    localparam logic [AW-1:0] PAGE_BASE = AW'(PAGE_WORDS);
    localparam logic [7:0]    CLR_LAST = 8'hFF;

    fees_pkg::state_t state_reg, state_next;

    logic              active_reg;
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     to_reg;
    logic [IW-1:0]     iss_reg;
    logic              pend_reg;
    logic [7:0]        clr_reg;
    logic              vb_reg;
    logic [31:0]       wb_reg;
    logic              vb2_reg;
    logic [7:0]        idb2_reg;
    logic              seen_rd_reg;
    logic              func_reg;
    logic [7:0]        id_reg;
    logic [15:0]       val_reg;
    logic [7:0]        c1_reg;
    logic [7:0]        wc_reg;
    logic [7:0]        kc_reg;
    logic [15:0]       d_reg;
    logic [7:0]        sc_reg;
    logic [2:0]        st_reg;
    logic              rsp_valid_reg;
    fees_pkg::rsp_beat_t rsp_reg;

    // one mark per identifier, cleared before each transfer
    logic seen_mem [256];

    logic          accept;
    logic          match;
    logic          scan_end;
    logic          xfer_end;
    logic          xfer_copy;
    logic          dup;
    logic          rsp_free;
    logic [7:0]    rid;
    logic [AW-1:0] act_base;
    logic [AW-1:0] new_base;
    logic          seen_we;
    logic [7:0]    seen_waddr;
    logic          seen_wdata;

    assign accept    = req_valid && !req_stall;
    assign rid       = mem_rdata[15:8];
    assign match     = pend_reg && (rid == id_reg);
    assign scan_end  = (iss_reg == '0) && !match;
    assign xfer_end  = (iss_reg == '0) && !pend_reg && !vb_reg;
    // the previous word's mark is still being written when this one is looked up
    assign dup       = vb2_reg && (idb2_reg == wb_reg[15:8]);
    assign xfer_copy = vb_reg && !seen_rd_reg && !dup;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign act_base  = active_reg ? PAGE_BASE : '0;
    assign new_base  = active_reg ? '0 : PAGE_BASE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fees_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.identifier == fees_pkg::ID_BLANK)
                        state_next = fees_pkg::S_DONE;
                    else if (req.func == fees_pkg::FUNC_WRITE)
                        state_next = fees_pkg::S_WCRC1;
                    else
                        state_next = fees_pkg::S_SCAN;
                end
            end
            fees_pkg::S_WCRC1:  state_next = fees_pkg::S_WCRC2;
            fees_pkg::S_WCRC2:  state_next = fees_pkg::S_SCAN;
            fees_pkg::S_SCAN:
            begin
                if (match)
                    state_next = fees_pkg::S_CHK1;
                else if (scan_end)
                    state_next = fees_pkg::S_DECIDE;
            end
            fees_pkg::S_CHK1:   state_next = fees_pkg::S_CHK2;
            fees_pkg::S_CHK2:   state_next = fees_pkg::S_DECIDE;
            fees_pkg::S_DECIDE:
            begin
                if (func_reg == fees_pkg::FUNC_READ)
                    state_next = fees_pkg::S_DONE;
                else if (st_reg == fees_pkg::ST_OK && d_reg == val_reg)
                    state_next = fees_pkg::S_DONE;
                else if (fill_reg == FILL_MAX)
                    state_next = fees_pkg::S_CLEAR;
                else
                    state_next = fees_pkg::S_APPEND;
            end
            fees_pkg::S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                    state_next = fees_pkg::S_XFER;
            end
            fees_pkg::S_XFER:
            begin
                if (xfer_end)
                    state_next = fees_pkg::S_APPEND;
            end
            fees_pkg::S_APPEND: state_next = fees_pkg::S_DONE;
            fees_pkg::S_DONE:
            begin
                if (rsp_free)
                    state_next = fees_pkg::S_IDLE;
            end
            default:            state_next = fees_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall  = (state_reg != fees_pkg::S_IDLE);
        mem_raddr  = act_base + AW'(iss_reg);
        mem_we     = 1'b0;
        mem_waddr  = act_base + AW'(fill_reg);
        mem_wdata  = {val_reg, id_reg, wc_reg};
        seen_we    = 1'b0;
        seen_waddr = wb_reg[15:8];
        seen_wdata = 1'b1;
        unique case (state_reg)
            fees_pkg::S_CLEAR:
            begin
                seen_we    = 1'b1;
                seen_waddr = clr_reg;
                seen_wdata = 1'b0;
            end
            fees_pkg::S_XFER:
            begin
                mem_we    = xfer_copy && (to_reg != FILL_MAX);
                mem_waddr = new_base + AW'(to_reg);
                mem_wdata = wb_reg;
                seen_we   = vb_reg;
            end
            fees_pkg::S_APPEND:
            begin
                mem_we = (fill_reg != FILL_MAX);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        seen_rd_reg <= seen_mem[rid];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fees_pkg::S_IDLE;
            active_reg    <= 1'b0;
            fill_reg      <= FW'(1);
            to_reg        <= FW'(1);
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
            vb_reg        <= 1'b0;
            wb_reg        <= '0;
            vb2_reg       <= 1'b0;
            idb2_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fees_pkg::S_DONE && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                fees_pkg::S_IDLE:
                begin
                    pend_reg <= 1'b0;
                    iss_reg  <= IW'(fill_reg - FW'(1));
                end
                fees_pkg::S_SCAN:
                begin
                    pend_reg <= (iss_reg != '0);
                    if (iss_reg != '0)
                        iss_reg <= iss_reg - IW'(1);
                end
                fees_pkg::S_DECIDE:
                begin
                    // start the transfer from the top of the old page
                    pend_reg <= 1'b0;
                    iss_reg  <= TOP_IDX;
                    to_reg   <= FW'(1);
                    clr_reg  <= '0;
                    vb_reg   <= 1'b0;
                    vb2_reg  <= 1'b0;
                end
                fees_pkg::S_CLEAR:
                begin
                    clr_reg <= clr_reg + 8'd1;
                end
                fees_pkg::S_XFER:
                begin
                    pend_reg <= (iss_reg != '0);
                    if (iss_reg != '0)
                        iss_reg <= iss_reg - IW'(1);
                    vb_reg   <= pend_reg;
                    wb_reg   <= mem_rdata;
                    vb2_reg  <= vb_reg;
                    idb2_reg <= wb_reg[15:8];
                    if (xfer_copy && (to_reg != FILL_MAX))
                        to_reg <= to_reg + FW'(1);
                    if (xfer_end)
                    begin
                        active_reg <= !active_reg;
                        fill_reg   <= to_reg;
                    end
                end
                fees_pkg::S_APPEND:
                begin
                    if (fill_reg != FILL_MAX)
                        fill_reg <= fill_reg + FW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fees_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_reg <= req.func;
                    id_reg   <= req.identifier;
                    val_reg  <= req.write_value;
                    c1_reg   <= fees_pkg::CRC_INIT
                                ^ fees_pkg::crc_byte(req.identifier ^ fees_pkg::CRC_INIT);
                    st_reg   <= (req.func == fees_pkg::FUNC_WRITE)
                                ? fees_pkg::ST_REJECTED : fees_pkg::ST_NOT_FOUND;
                    d_reg    <= '0;
                end
            end
            fees_pkg::S_WCRC1: wc_reg <= fees_pkg::crc_byte(val_reg[7:0] ^ c1_reg);
            fees_pkg::S_WCRC2: wc_reg <= fees_pkg::crc_byte(val_reg[15:8] ^ wc_reg);
            fees_pkg::S_SCAN:
            begin
                if (match)
                begin
                    d_reg  <= mem_rdata[31:16];
                    sc_reg <= mem_rdata[7:0];
                end
                else if (scan_end)
                begin
                    st_reg <= fees_pkg::ST_NOT_FOUND;
                end
            end
            fees_pkg::S_CHK1: kc_reg <= fees_pkg::crc_byte(d_reg[7:0] ^ c1_reg);
            fees_pkg::S_CHK2:
            begin
                st_reg <= (fees_pkg::crc_byte(d_reg[15:8] ^ kc_reg) == sc_reg)
                          ? fees_pkg::ST_OK : fees_pkg::ST_CRC_BAD;
            end
            fees_pkg::S_DECIDE:
            begin
                if (func_reg == fees_pkg::FUNC_WRITE)
                    st_reg <= fees_pkg::ST_OK;
                else if (st_reg == fees_pkg::ST_NOT_FOUND)
                    d_reg <= '0;
            end
            fees_pkg::S_APPEND:
            begin
                st_reg <= (fill_reg == FILL_MAX) ? fees_pkg::ST_FULL : fees_pkg::ST_OK;
            end
            fees_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_reg.status     <= st_reg;
                    rsp_reg.read_value <= (func_reg == fees_pkg::FUNC_READ) ? d_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/flash_eeprom_record_store_top.sv -----
// Top level of the flash EEPROM record store.
// Depends on fees_pkg, fees_ctrl and fees_flash_mem.
//
// Usage: one request beat (func, identifier, write_value) on req, one response
// beat (status, read_value) on rsp per request. Both channels use valid/stall;
// a beat moves when valid is high and stall is low.
// A read scans the active page from the newest record down, one word per cycle
// from the single read port of the flash array, and returns the newest match.
// A write scans the same way, then appends one record unless the newest match
// holds the same value with a good CRC. The scan starts just below fill (at most
// PAGE_WORDS), the next free word of the active page. A write that finds the page
// full first clears the seen table of 256 marks, then walks the old page one word
// per cycle through the read port.
// One request is in flight at a time; req_stall is high until its response is
// registered, and the next request is taken while that response waits.
// Reset formats the store at once: page 0 active and empty; no sweep of the
// array is needed since only written words below the fill point are read.
// While rsp_stall is high the response holds and the block waits before taking
// a further response.
module flash_eeprom_record_store_top #(
    parameter int PAGE_WORDS = fees_pkg::PAGE_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fees_pkg::req_beat_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fees_pkg::rsp_beat_t rsp
);

    localparam int AW = $clog2(2 * PAGE_WORDS);

    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    fees_ctrl #(
        .PAGE_WORDS (PAGE_WORDS),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    fees_flash_mem #(
        .DEPTH (2 * PAGE_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

endmodule
